// ===== sv/pli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the phase lag index accumulator.
// ---------------------------------------------------------------------------
package pli_pkg;
   localparam int SampleBits = 16;
   localparam int ProdBits   = 33;
   localparam int SqBits     = 64;
   localparam int MagBits    = 32;
   localparam int AccBits    = 49;
   localparam int CountBits  = 17;
   localparam logic [CountBits-1:0] MaxWindow = 17'd65536;
   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_SHORT = 2'd1,
      STATUS_ZERO_NORM = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] real_a;
      logic signed [SampleBits-1:0] quad_a;
      logic signed [SampleBits-1:0] real_b;
      logic signed [SampleBits-1:0] quad_b;
      logic                         last_sample;
   } req_type;

   typedef struct packed {
      logic [15:0] connectivity;
      logic [1:0]  status;
   } rsp_type;

   // one queue entry: classified sample for the back end
   typedef struct packed {
      logic signed [ProdBits-1:0] im;
      logic                       accum;
      logic                       last_sample;
   } work_type;

   typedef enum logic [1:0] {
      BE_RUN  = 2'd0,
      BE_SQRT = 2'd1,
      BE_DIV  = 2'd2,
      BE_OUT  = 2'd3
   } be_state_type;
endpackage
`default_nettype wire

// ===== sv/pli_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pli_req_if / pli_rsp_if
// Valid/ready channels of the phase lag index accumulator.
// ---------------------------------------------------------------------------
interface pli_req_if;
   logic valid;
   logic ready;
   pli_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pli_rsp_if;
   logic valid;
   logic ready;
   pli_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pli_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pli_front
// Accepts samples, forms the cross product and squared magnitude in stages.
// The window count decides whether a sample is accumulated.
// ---------------------------------------------------------------------------
module pli_front (
   input  wire logic              clock,
   input  wire logic              reset,
   pli_req_if.sink                req,
   input  wire logic              q_full,
   output pli_pkg::work_type      s_work,
   output logic [pli_pkg::SqBits-1:0] s_sq,
   output logic                   s_valid
);
   import pli_pkg::*;

   logic [CountBits-1:0] count_ff, count_in;
   // stage 1: four products
   logic                          v1_ff;
   logic signed [2*SampleBits-1:0] p_rr_ff, p_qq_ff, p_qr_ff, p_rq_ff;
   logic                          acc1_ff, last1_ff;
   // stage 2: re, im
   logic                          v2_ff;
   logic signed [ProdBits-1:0]    re2_ff, im2_ff;
   logic                          acc2_ff, last2_ff;
   // stage 3: squares
   logic                          v3_ff;
   logic [SqBits-2:0]             re_sq_ff, im_sq_ff;
   logic signed [ProdBits-1:0]    im3_ff;
   logic                          acc3_ff, last3_ff;
   logic [ProdBits-1:0]           are, aim;
   logic                          take, accum;

   // one sample at a time in flight plus queue room: stall when queue full
   assign req.ready = !q_full && !v1_ff && !v2_ff && !v3_ff;
   assign take      = req.valid && req.ready;
   assign accum     = count_ff < MaxWindow;

   // window count
   always_comb begin
      count_in = count_ff;
      if (take) begin
         if (req.data.last_sample) count_in = '0;
         else if (accum)           count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         v1_ff <= take; v2_ff <= v1_ff; v3_ff <= v2_ff;
      end
   end

   always_comb begin
      are = re2_ff[ProdBits-1] ? ProdBits'(-re2_ff) : ProdBits'(re2_ff);
      aim = im2_ff[ProdBits-1] ? ProdBits'(-im2_ff) : ProdBits'(im2_ff);
   end

   // datapath stages
   always_ff @(posedge clock) begin
      p_rr_ff  <= req.data.real_a * req.data.real_b;
      p_qq_ff  <= req.data.quad_a * req.data.quad_b;
      p_qr_ff  <= req.data.quad_a * req.data.real_b;
      p_rq_ff  <= req.data.real_a * req.data.quad_b;
      acc1_ff  <= accum;
      last1_ff <= req.data.last_sample;
      re2_ff   <= ProdBits'(p_rr_ff) + ProdBits'(p_qq_ff);
      im2_ff   <= ProdBits'(p_qr_ff) - ProdBits'(p_rq_ff);
      acc2_ff  <= acc1_ff;
      last2_ff <= last1_ff;
      re_sq_ff <= (SqBits-1)'(are * are);
      im_sq_ff <= (SqBits-1)'(aim * aim);
      im3_ff   <= im2_ff;
      acc3_ff  <= acc2_ff;
      last3_ff <= last2_ff;
   end

   assign s_valid = v3_ff;
   assign s_sq    = SqBits'(re_sq_ff) + SqBits'(im_sq_ff);
   always_comb begin
      s_work.im          = im3_ff;
      s_work.accum       = acc3_ff;
      s_work.last_sample = last3_ff;
   end
endmodule
`default_nettype wire

// ===== sv/pli_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pli_queue
// Short FIFO between front and back end; carries sample plus squared norm.
// ---------------------------------------------------------------------------
module pli_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire pli_pkg::work_type wr_work,
   input  wire logic [pli_pkg::SqBits-1:0] wr_sq,
   output logic                   full,
   output logic                   empty,
   input  wire logic              rd_en,
   output pli_pkg::work_type      rd_work,
   output logic [pli_pkg::SqBits-1:0] rd_sq
);
   import pli_pkg::*;

   work_type          work_ff [QueueDepth];
   logic [SqBits-1:0] sq_ff   [QueueDepth];
   logic [QueueAw-1:0] wp_ff, rp_ff;
   logic [QueueAw:0]   cnt_ff;

   assign full    = cnt_ff == (QueueAw+1)'(QueueDepth);
   assign empty   = cnt_ff == '0;
   assign rd_work = work_ff[rp_ff];
   assign rd_sq   = sq_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         work_ff[wp_ff] <= wr_work;
         sq_ff[wp_ff]   <= wr_sq;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QueueAw+1)'(wr_en) - (QueueAw+1)'(rd_en);
      end
   end
endmodule
`default_nettype wire

// ===== sv/pli_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pli_back
// Takes queued samples: iterative square root (one result bit per cycle),
// accumulation, and on the last sample a restoring divide (one bit a cycle).
// ---------------------------------------------------------------------------
module pli_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire pli_pkg::work_type q_work,
   input  wire logic [pli_pkg::SqBits-1:0] q_sq,
   output logic                   q_rd,
   pli_rsp_if.source              rsp
);
   import pli_pkg::*;

   be_state_type state_ff, state_in;
   logic [MagBits-1:0]  root_ff;
   logic [5:0]          step_ff;
   logic signed [ProdBits-1:0] im_ff;
   logic                acc_ff, last_ff;
   logic [CountBits-1:0] cnt_ff;
   logic [AccBits-1:0]  isum_ff, msum_ff;
   logic [AccBits+16:0] drem_ff;
   logic [16:0]         quot_ff;
   logic [4:0]          dstep_ff;
   logic                rsp_v_ff;
   rsp_type             rsp_ff;
   logic [AccBits-1:0]  aisum;
   logic [SqBits+1:0]   trial;
   logic [AccBits+17:0] dtrial;
   logic                done_sqrt, dquot;
   logic [SqBits+1:0]   sq_rem_ff;
   logic [SqBits-1:0]   rad_ff;
   logic [SqBits+1:0]   sq_next;

   // square root: remainder shifts in two bits of the radicand per step
   always_comb trial = (SqBits+2)'({root_ff, 2'b01});

   always_comb begin
      sq_next = {sq_rem_ff[SqBits-1:0], rad_ff[SqBits-1:SqBits-2]};
   end
   assign done_sqrt = step_ff == 6'd31;

   always_comb aisum = isum_ff[AccBits-1] ? AccBits'(-isum_ff) : isum_ff;
   always_comb dtrial = {drem_ff, 1'b0} - (AccBits+18)'(msum_ff);
   assign dquot = !dtrial[AccBits+17];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_RUN:  if (!q_empty) state_in = BE_SQRT;
         BE_SQRT: if (done_sqrt) state_in = last_ff ? BE_DIV : BE_RUN;
         BE_DIV:  if (dstep_ff == 5'd16) state_in = BE_OUT;
         BE_OUT:  if (!rsp_v_ff) state_in = BE_RUN;
         default: state_in = BE_RUN;
      endcase
   end

   // outputs
   always_comb begin
      q_rd = 1'b0;
      case (state_ff)
         BE_RUN:  q_rd = !q_empty;
         default: q_rd = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BE_RUN;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; isum_ff <= '0; msum_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_v_ff <= 1'b0;
         case (state_ff)
            BE_RUN: begin
               if (!q_empty) begin
                  rad_ff    <= q_sq;
                  sq_rem_ff <= '0;
                  root_ff   <= '0;
                  step_ff   <= '0;
                  im_ff     <= q_work.im;
                  acc_ff    <= q_work.accum;
                  last_ff   <= q_work.last_sample;
               end
            end
            BE_SQRT: begin
               rad_ff  <= {rad_ff[SqBits-3:0], 2'b00};
               step_ff <= step_ff + 1'b1;
               if (sq_next >= trial) begin
                  sq_rem_ff <= sq_next - trial;
                  root_ff   <= {root_ff[MagBits-2:0], 1'b1};
               end else begin
                  sq_rem_ff <= sq_next;
                  root_ff   <= {root_ff[MagBits-2:0], 1'b0};
               end
               if (done_sqrt && acc_ff) begin
                  isum_ff <= isum_ff + AccBits'(im_ff);
                  msum_ff <= msum_ff + AccBits'({root_ff[MagBits-2:0],
                                                 sq_next >= trial});
                  cnt_ff  <= cnt_ff + 1'b1;
               end
               drem_ff  <= '0;
               quot_ff  <= '0;
               dstep_ff <= '0;
            end
            BE_DIV: begin
               // first step loads the dividend |isum|<<16 bit-serially
               if (dstep_ff == 5'd0) begin
                  drem_ff  <= (AccBits+17)'(aisum);
                  dstep_ff <= 5'd1;
               end else begin
                  if (dquot) drem_ff <= (AccBits+17)'(dtrial);
                  else       drem_ff <= {drem_ff[AccBits+15:0], 1'b0};
                  quot_ff  <= {quot_ff[15:0], dquot};
                  dstep_ff <= dstep_ff + 1'b1;
               end
            end
            BE_OUT: begin
               if (!rsp_v_ff) begin
                  rsp_v_ff <= 1'b1;
                  if (cnt_ff < (CountBits)'(2)) begin
                     rsp_ff.status <= STATUS_TOO_SHORT;
                     rsp_ff.connectivity <= '0;
                  end else if (msum_ff == '0) begin
                     rsp_ff.status <= STATUS_ZERO_NORM;
                     rsp_ff.connectivity <= '0;
                  end else begin
                     rsp_ff.status <= STATUS_OK;
                     rsp_ff.connectivity <= (quot_ff[16] || aisum >= msum_ff)
                                            ? 16'hFFFF : quot_ff[15:0];
                  end
                  cnt_ff <= '0; isum_ff <= '0; msum_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;
endmodule
`default_nettype wire

// ===== sv/phase_lag_index_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// phase_lag_index_accumulator
// Weighted phase lag index over a window of analytic sample pairs.
// ---------------------------------------------------------------------------
// After a sample is accepted, the front end holds off new samples while the
// products pass its three stages. The back end pops each sample from the
// queue and then runs 32 steps of a bit-serial square root that forms |p|;
// this work sets the throughput once the four-entry queue has filled. The
// sample that closes a window adds a divide (one load step, then sixteen
// quotient bits) and a state that registers the result item. A result item
// not yet taken stalls the back end only when the next window closes; the
// window state clears as the result item is formed.
module phase_lag_index_accumulator (
   input  wire logic clock,
   input  wire logic reset,
   pli_req_if.sink   req,
   pli_rsp_if.source rsp
);
   import pli_pkg::*;

   work_type          f_work, q_work;
   logic [SqBits-1:0] f_sq, q_sq;
   logic              f_valid, q_full, q_empty, q_rd;

   pli_front u_front (.clock, .reset, .req, .q_full,
      .s_work(f_work), .s_sq(f_sq), .s_valid(f_valid));

   pli_queue u_queue (.clock, .reset, .wr_en(f_valid), .wr_work(f_work),
      .wr_sq(f_sq), .full(q_full), .empty(q_empty), .rd_en(q_rd),
      .rd_work(q_work), .rd_sq(q_sq));

   pli_back u_back (.clock, .reset, .q_empty, .q_work, .q_sq, .q_rd, .rsp);

   // never read an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_rd |-> !q_empty) else $error("queue underflow");
   // never write a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      f_valid |-> !q_full) else $error("queue overflow");
   // status code is one of the defined ones
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.status == STATUS_OK ||
                     rsp.data.status == STATUS_TOO_SHORT ||
                     rsp.data.status == STATUS_ZERO_NORM))
      else $error("bad status");
endmodule
`default_nettype wire
